// ===== rtl/dur_pkg.sv =====
// ----------------------------------------------------------------------------
// dur_pkg: shared types and constants of the dual ultrasonic ranger
// Action, sensor and steering codes, the distance scale factor and the
// result item carried from the ranging core to the output register.
// ----------------------------------------------------------------------------
package dur_pkg;

  localparam int TS_W   = 16;
  localparam int DIST_W = 16;
  localparam int CODE_W = 2;

  // Distance = (width * SCALE_MUL) >> SCALE_SHIFT, about width / 1.93.
  localparam logic [15:0] SCALE_MUL   = 16'd33957;
  localparam int          SCALE_SHIFT = 16;

  localparam logic [DIST_W-1:0] WARN_RESET = 16'd100;

  localparam logic [CODE_W-1:0] ACT_TICK  = 2'd0;
  localparam logic [CODE_W-1:0] ACT_ECHO1 = 2'd1;
  localparam logic [CODE_W-1:0] ACT_ECHO2 = 2'd2;

  localparam logic [CODE_W-1:0] SENS_NONE = 2'd0;
  localparam logic [CODE_W-1:0] SENS_ONE  = 2'd1;
  localparam logic [CODE_W-1:0] SENS_TWO  = 2'd2;

  localparam logic [CODE_W-1:0] STEER_NONE     = 2'd0;
  localparam logic [CODE_W-1:0] STEER_STRAIGHT = 2'd1;
  localparam logic [CODE_W-1:0] STEER_RIGHT    = 2'd2;
  localparam logic [CODE_W-1:0] STEER_LEFT     = 2'd3;

  typedef struct packed {
    logic [CODE_W-1:0] trigger_sensor;
    logic              distance_valid;
    logic [CODE_W-1:0] distance_sensor;
    logic [DIST_W-1:0] distance;
    logic [CODE_W-1:0] steer;
  } res_t;

endpackage

// ===== rtl/dual_ultrasonic_ranger.sv =====
// ----------------------------------------------------------------------------
// dual_ultrasonic_ranger: two-sensor ultrasonic ranging with steering
// Alternates two sensors, turns echo edge timestamps into distances and
// decides how to steer after each pair of measurements.
//
//   channel  direction  handshake               content
//   in_      input      in_valid / in_ready     action, edge_rising, timestamp
//   out_     output     out_valid / out_ready   trigger, distance, steer
//   cfg_     input      cfg_valid / cfg_ready   warn_distance
//
// One item per cycle while out_ready keeps the output register free. An item
// is held in the input register, and its result then in the output register,
// where it is offered on out_valid.
// Reset arms sensor one and sets warn_distance to 100.
// While out_ready is low a full output register holds its result and the
// input register still takes one more item.
// ----------------------------------------------------------------------------
module dual_ultrasonic_ranger (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dur_pkg::CODE_W-1:0] in_action,
  input  logic                       in_edge_rising,
  input  logic [dur_pkg::TS_W-1:0]   in_timestamp,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [dur_pkg::CODE_W-1:0] out_trigger_sensor,
  output logic                       out_distance_valid,
  output logic [dur_pkg::CODE_W-1:0] out_distance_sensor,
  output logic [dur_pkg::DIST_W-1:0] out_distance,
  output logic [dur_pkg::CODE_W-1:0] out_steer,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [dur_pkg::DIST_W-1:0] cfg_data
);
  import dur_pkg::*;

  logic              in_v_r;
  logic [CODE_W-1:0] action_r;
  logic              rising_r;
  logic [TS_W-1:0]   ts_r;
  logic              out_v_r;
  res_t              out_r;
  res_t              res;
  logic [DIST_W-1:0] warn_r;
  logic              advance;

  assign advance   = in_v_r && (!out_v_r || out_ready);
  assign in_ready  = !in_v_r || advance;
  assign cfg_ready = 1'b1;

  dur_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .action        (action_r),
    .edge_rising   (rising_r),
    .timestamp     (ts_r),
    .warn_distance (warn_r),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      warn_r  <= WARN_RESET;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_valid) begin
        warn_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      action_r <= in_action;
      rising_r <= in_edge_rising;
      ts_r     <= in_timestamp;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_v_r;
  assign out_trigger_sensor  = out_r.trigger_sensor;
  assign out_distance_valid  = out_r.distance_valid;
  assign out_distance_sensor = out_r.distance_sensor;
  assign out_distance        = out_r.distance;
  assign out_steer           = out_r.steer;

endmodule

// ===== rtl/dur_scale.sv =====
// ----------------------------------------------------------------------------
// dur_scale: echo width to distance
// Forms the echo width from two capture timestamps, taking a wrap of the
// timer into account, and scales it to a distance with one constant multiply.
// ----------------------------------------------------------------------------
module dur_scale (
  input  logic [dur_pkg::TS_W-1:0]   start_ts,
  input  logic [dur_pkg::TS_W-1:0]   end_ts,
  output logic [dur_pkg::DIST_W-1:0] distance
);
  import dur_pkg::*;

  logic [TS_W-1:0]          diff;
  logic [TS_W:0]            width;
  logic [TS_W+15:0]         prod;

  // Modulo difference; equal timestamps mean one full timer period.
  assign diff     = end_ts - start_ts;
  assign width    = {(diff == '0), diff};
  assign prod     = (TS_W+16)'(width) * (TS_W+16)'(SCALE_MUL);
  assign distance = prod[SCALE_SHIFT +: DIST_W];

endmodule

// ===== rtl/dur_core.sv =====
// ----------------------------------------------------------------------------
// dur_core: ranging state and result logic
// Holds the sensor sequencing state, the echo start timestamps and the last
// distances, and forms the result item for the item presented on step.
// ----------------------------------------------------------------------------
module dur_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [dur_pkg::CODE_W-1:0] action,
  input  logic                       edge_rising,
  input  logic [dur_pkg::TS_W-1:0]   timestamp,
  input  logic [dur_pkg::DIST_W-1:0] warn_distance,
  output dur_pkg::res_t              res
);
  import dur_pkg::*;

  logic [CODE_W-1:0] due_r, due_nxt;
  logic [CODE_W-1:0] listen_r, listen_nxt;
  logic              rise1_r, rise1_nxt;
  logic              rise2_r, rise2_nxt;
  logic [TS_W-1:0]   start1_r, start1_nxt;
  logic [TS_W-1:0]   start2_r, start2_nxt;
  logic [DIST_W-1:0] dist1_r, dist1_nxt;
  logic [DIST_W-1:0] dist2_r, dist2_nxt;
  logic [TS_W-1:0]   start_sel;
  logic [DIST_W-1:0] echo_dist;

  assign start_sel = (action == ACT_ECHO2) ? start2_r : start1_r;

  dur_scale u_scale (
    .start_ts (start_sel),
    .end_ts   (timestamp),
    .distance (echo_dist)
  );

  always_comb begin
    due_nxt    = due_r;
    listen_nxt = listen_r;
    rise1_nxt  = rise1_r;
    rise2_nxt  = rise2_r;
    start1_nxt = start1_r;
    start2_nxt = start2_r;
    dist1_nxt  = dist1_r;
    dist2_nxt  = dist2_r;
    res        = '0;
    case (action)
      ACT_TICK: begin
        if (due_r == SENS_ONE) begin
          due_nxt            = SENS_NONE;
          listen_nxt         = SENS_ONE;
          rise1_nxt          = 1'b0;
          res.trigger_sensor = SENS_ONE;
        end else if (due_r == SENS_TWO) begin
          due_nxt            = SENS_NONE;
          listen_nxt         = SENS_TWO;
          rise2_nxt          = 1'b0;
          res.trigger_sensor = SENS_TWO;
        end
      end
      ACT_ECHO1: begin
        if (listen_r == SENS_ONE) begin
          if (!rise1_r) begin
            if (edge_rising) begin
              start1_nxt = timestamp;
              rise1_nxt  = 1'b1;
            end
          end else if (!edge_rising) begin
            dist1_nxt           = echo_dist;
            rise1_nxt           = 1'b0;
            listen_nxt          = SENS_NONE;
            due_nxt             = SENS_TWO;
            res.distance_valid  = 1'b1;
            res.distance_sensor = SENS_ONE;
            res.distance        = echo_dist;
          end
        end
      end
      ACT_ECHO2: begin
        if (listen_r == SENS_TWO) begin
          if (!rise2_r) begin
            if (edge_rising) begin
              start2_nxt = timestamp;
              rise2_nxt  = 1'b1;
            end
          end else if (!edge_rising) begin
            dist2_nxt           = echo_dist;
            rise2_nxt           = 1'b0;
            listen_nxt          = SENS_NONE;
            due_nxt             = SENS_ONE;
            res.distance_valid  = 1'b1;
            res.distance_sensor = SENS_TWO;
            res.distance        = echo_dist;
            if (dist1_r < warn_distance && echo_dist < warn_distance) begin
              res.steer = STEER_STRAIGHT;
            end else if (dist1_r > echo_dist) begin
              res.steer = STEER_RIGHT;
            end else begin
              res.steer = STEER_LEFT;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      due_r    <= SENS_ONE;
      listen_r <= SENS_NONE;
      rise1_r  <= 1'b0;
      rise2_r  <= 1'b0;
      start1_r <= '0;
      start2_r <= '0;
      dist1_r  <= '0;
      dist2_r  <= '0;
    end else if (step) begin
      due_r    <= due_nxt;
      listen_r <= listen_nxt;
      rise1_r  <= rise1_nxt;
      rise2_r  <= rise2_nxt;
      start1_r <= start1_nxt;
      start2_r <= start2_nxt;
      dist1_r  <= dist1_nxt;
      dist2_r  <= dist2_nxt;
    end
  end

  // A sensor is either due or listening, never both at once.
  a_due_or_listen: assert property (@(posedge clk) disable iff (!rst_n)
    (due_r != SENS_NONE) |-> (listen_r == SENS_NONE))
    else $error("sensor due while another is listening");

  a_one_then_two: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.distance_valid && res.distance_sensor == SENS_ONE) |=>
    (due_r == SENS_TWO))
    else $error("sensor two not due after sensor one completed");

  a_steer_on_two: assert property (@(posedge clk) disable iff (!rst_n)
    (res.steer != STEER_NONE) |-> (res.distance_sensor == SENS_TWO))
    else $error("steering decided without a sensor two measurement");

  a_trigger_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (res.trigger_sensor != SENS_NONE) |-> (!res.distance_valid && listen_r == SENS_NONE))
    else $error("trigger fired during a measurement");

endmodule
